>>> rtl/ring_buffer_frame_packer_unit_macros.svh
// Assertion macros used by the checker file of the frame packer.
`ifndef RING_BUFFER_FRAME_PACKER_UNIT_MACROS_SVH
`define RING_BUFFER_FRAME_PACKER_UNIT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define RBFP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define RBFP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/rbfp_pkg.sv
// Shared types and constants of the ring buffer frame packer.
`default_nettype none

package rbfp_pkg;

  localparam int unsigned RingDepthDef    = 256;
  localparam int unsigned FramePayloadDef = 63;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned IdxW            = 6;
  localparam int unsigned TimeoutW        = 8;

  localparam logic [TimeoutW-1:0] TimeoutRst = 8'd5;

  // Input command codes.
  localparam logic CmdPush = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic             command;
    logic [ByteW-1:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic [IdxW-1:0]  byte_index;
    logic             last;
    logic             overflow_seen;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic issue;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_frame;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/rbfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rbfp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rbfp_ctrl.sv
// Controller: accepts beats, sequences frame reads and runs the output handshake.
`default_nettype none

module rbfp_ctrl #(
  parameter int unsigned FRAME_PAYLOAD = rbfp_pkg::FramePayloadDef,
  localparam int unsigned FrameLen = FRAME_PAYLOAD + 1,
  localparam int unsigned PosW     = $clog2(FrameLen)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  input  wire rbfp_pkg::dp_status_t   status_i,
  output rbfp_pkg::dp_cmd_t           cmd_o,
  output logic [PosW-1:0]             pos_o
);

  typedef enum logic {
    StIdle,
    StSend
  } state_e;

  state_e          state_q;
  logic [PosW-1:0] pos_q;
  logic            s1_valid_q;
  logic            out_valid_q;

  logic accept;
  logic advance;
  logic issue;
  logic out_load;
  logic last_pos;

  always_comb begin
    accept   = in_valid_i && (state_q == StIdle);
    advance  = !out_valid_q || out_ready_i;
    issue    = (state_q == StSend) && (!s1_valid_q || advance);
    out_load = s1_valid_q && advance;
    last_pos = (pos_q == PosW'(FrameLen - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept && status_i.start_frame) begin
            state_q <= StSend;
            pos_q   <= '0;
          end
        end
        StSend: begin
          if (issue) begin
            if (last_pos) begin
              state_q <= StIdle;
            end else begin
              pos_q <= pos_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
      s1_valid_q  <= issue || (s1_valid_q && !advance);
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.accept   = accept;
  assign cmd_o.issue    = issue;
  assign cmd_o.out_load = out_load;
  assign pos_o          = pos_q;

endmodule

`default_nettype wire

>>> rtl/rbfp_datapath.sv
// Datapath: ring pointers, wait counter, overflow flag, ring RAM and frame byte registers.
`default_nettype none

module rbfp_datapath #(
  parameter int unsigned RING_DEPTH    = rbfp_pkg::RingDepthDef,
  parameter int unsigned FRAME_PAYLOAD = rbfp_pkg::FramePayloadDef,
  localparam int unsigned FrameLen = FRAME_PAYLOAD + 1,
  localparam int unsigned PosW     = $clog2(FrameLen)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire rbfp_pkg::in_beat_t                  in_beat_i,
  input  wire rbfp_pkg::dp_cmd_t                   cmd_i,
  input  wire logic [PosW-1:0]                     pos_i,
  output rbfp_pkg::dp_status_t                     status_o,
  input  wire logic                                cfg_valid_i,
  input  wire logic [rbfp_pkg::TimeoutW-1:0]       cfg_data_i,
  output rbfp_pkg::out_beat_t                      out_beat_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [AW:0] DepthW = (AW + 1)'(RING_DEPTH);

  logic [AW-1:0]                   rp_q, wp_q, raddr_q;
  logic [rbfp_pkg::TimeoutW-1:0]   wait_q, timeout_q;
  logic                            ovf_q;
  logic [PosW-1:0]                 frame_n_q;
  logic                            frame_ovf_q;
  logic [PosW-1:0]                 s1_pos_q;
  logic                            s1_data_q;
  logic                            s1_ovf_q;
  rbfp_pkg::out_beat_t             out_q;

  logic [AW:0]                     diff, diff_wrap, rp_sum;
  logic [AW-1:0]                   pending, rp_next, wp_next, raddr_next;
  logic                            full, empty, have_full, timed_out, is_push;
  logic                            tick_frame, ram_we, ram_re, is_data;
  logic [rbfp_pkg::TimeoutW-1:0]   wait_inc;
  logic [PosW-1:0]                 frame_n;
  logic [rbfp_pkg::ByteW-1:0]      ram_rdata;

  always_comb begin
    diff       = {1'b0, wp_q} - {1'b0, rp_q};
    diff_wrap  = diff + DepthW;
    pending    = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
    full       = (pending == AW'(RING_DEPTH - 1));
    empty      = (pending == '0);
    have_full  = (int'(pending) >= int'(FRAME_PAYLOAD));
    wait_inc   = wait_q + 1'b1;
    timed_out  = (wait_inc == timeout_q);
    is_push    = (in_beat_i.command == rbfp_pkg::CmdPush);
    tick_frame = !is_push && !empty && (have_full || timed_out);
    frame_n    = have_full ? PosW'(FRAME_PAYLOAD) : PosW'(pending);
    rp_sum     = {1'b0, rp_q} + (AW + 1)'(frame_n);
    rp_next    = (rp_sum >= DepthW) ? AW'(rp_sum - DepthW) : rp_sum[AW-1:0];
    wp_next    = (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    raddr_next = (raddr_q == AW'(RING_DEPTH - 1)) ? '0 : raddr_q + 1'b1;
    ram_we     = cmd_i.accept && is_push && !full;
    // Positions 1..n carry stored bytes; position 0 is the count.
    is_data    = (pos_i != '0) && (pos_i <= frame_n_q);
    ram_re     = cmd_i.issue && is_data;
  end

  assign status_o.start_frame = tick_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q      <= '0;
      wp_q      <= '0;
      wait_q    <= '0;
      ovf_q     <= 1'b0;
      timeout_q <= rbfp_pkg::TimeoutRst;
    end else begin
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        if (is_push) begin
          if (full) begin
            ovf_q <= 1'b1;
          end else begin
            wp_q <= wp_next;
          end
        end else if (!empty) begin
          if (tick_frame) begin
            wait_q <= '0;
            rp_q   <= rp_next;
            ovf_q  <= 1'b0;
          end else begin
            wait_q <= wait_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && tick_frame) begin
      frame_n_q   <= frame_n;
      frame_ovf_q <= ovf_q;
      raddr_q     <= rp_q;
    end else if (ram_re) begin
      raddr_q <= raddr_next;
    end
    if (cmd_i.issue) begin
      s1_pos_q  <= pos_i;
      s1_data_q <= is_data;
      s1_ovf_q  <= frame_ovf_q;
    end
    if (cmd_i.out_load) begin
      if (s1_pos_q == '0) begin
        out_q.frame_byte <= rbfp_pkg::ByteW'(frame_n_q);
      end else if (s1_data_q) begin
        out_q.frame_byte <= ram_rdata;
      end else begin
        out_q.frame_byte <= '0;
      end
      out_q.byte_index    <= rbfp_pkg::IdxW'(s1_pos_q);
      out_q.last          <= (s1_pos_q == PosW'(FrameLen - 1));
      out_q.overflow_seen <= s1_ovf_q;
    end
  end

  rbfp_ram #(
    .Width (rbfp_pkg::ByteW),
    .Depth (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_beat_i.data_byte),
    .re_i    (ram_re),
    .raddr_i (raddr_q),
    .rdata_o (ram_rdata)
  );

  assign out_beat_o = out_q;

endmodule

`default_nettype wire

>>> rtl/ring_buffer_frame_packer_unit.sv
// Top level of the ring buffer frame packer: byte FIFO that packs its contents into frames.
//
//   Channel   Direction  Handshake                 Beat
//   in        input      in_valid_i / in_ready_o   rbfp_pkg::in_beat_t (push or send tick)
//   out       output     out_valid_o / out_ready_i rbfp_pkg::out_beat_t (one frame byte)
//   cfg       input      cfg_valid_i / cfg_ready_o send_timeout value, 8 bits
//
// Bytes can stream in at one per cycle while no frame is being sent.
// A send tick that does not start a frame leaves in_ready_o high.
// A tick that starts a frame holds in_ready_o low until the count byte and all
// FRAME_PAYLOAD byte positions are issued, which a stalled output holds back; the single
// read port of the ring RAM fetches one frame byte per cycle unless the output stalls.
// Reset clears pointers, wait counter, overflow flag and sets send_timeout to 5;
// the ring RAM is not cleared, there is no clearing pass.
// The output register parts the two sides: a new beat may be accepted while
// the last byte of a frame still waits for out_ready_i.
`default_nettype none

module ring_buffer_frame_packer_unit #(
  parameter int unsigned RING_DEPTH    = rbfp_pkg::RingDepthDef,
  parameter int unsigned FRAME_PAYLOAD = rbfp_pkg::FramePayloadDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rbfp_pkg::in_beat_t            in_beat_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rbfp_pkg::out_beat_t                out_beat_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rbfp_pkg::TimeoutW-1:0] cfg_data_i
);

  localparam int unsigned PosW = $clog2(FRAME_PAYLOAD + 1);

  rbfp_pkg::dp_cmd_t    cmd;
  rbfp_pkg::dp_status_t status;
  logic [PosW-1:0]      pos;

  // The timeout register can always take a write.
  assign cfg_ready_o = 1'b1;

  // The controller decides when beats move; the datapath decides what they carry.
  rbfp_ctrl #(
    .FRAME_PAYLOAD (FRAME_PAYLOAD)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd),
    .pos_o       (pos)
  );

  rbfp_datapath #(
    .RING_DEPTH    (RING_DEPTH),
    .FRAME_PAYLOAD (FRAME_PAYLOAD)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .pos_i       (pos),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

>>> rtl/rbfp_checker.sv
// Port-level checker for the frame packer and its bind to the top level.
`default_nettype none

`include "ring_buffer_frame_packer_unit_macros.svh"

module rbfp_checker #(
  parameter int unsigned FRAME_PAYLOAD = rbfp_pkg::FramePayloadDef
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire rbfp_pkg::in_beat_t            in_beat_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire rbfp_pkg::out_beat_t           out_beat_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [rbfp_pkg::TimeoutW-1:0] cfg_data_i
);

  localparam int unsigned PosW = $clog2(FRAME_PAYLOAD + 1);

  logic [PosW-1:0] exp_q;
  logic            ovf_q;
  logic            out_acc;
  logic            unused_in;

  assign out_acc   = out_valid_o && out_ready_i;
  assign unused_in = in_valid_i ^ in_ready_o ^ (^in_beat_i) ^ cfg_valid_i ^ cfg_ready_o
                     ^ (^cfg_data_i);

  // Expected position of the next output beat and the flag of the current frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      ovf_q <= 1'b0;
    end else if (out_acc) begin
      if (exp_q == '0) begin
        ovf_q <= out_beat_o.overflow_seen;
      end
      exp_q <= out_beat_o.last ? '0 : exp_q + 1'b1;
    end
  end

  `RBFP_ASSERT(a_index_seq, clk_i, rst_ni,
    out_valid_o |-> (out_beat_o.byte_index == rbfp_pkg::IdxW'(exp_q)),
    "frame byte index out of sequence")

  `RBFP_ASSERT(a_last_pos, clk_i, rst_ni,
    out_valid_o |-> (out_beat_o.last == (exp_q == PosW'(FRAME_PAYLOAD))),
    "last flag not on the final frame byte")

  `RBFP_ASSERT(a_ovf_frame, clk_i, rst_ni,
    (out_valid_o && (exp_q != '0)) |-> (out_beat_o.overflow_seen == ovf_q),
    "overflow flag changed within a frame")

  `RBFP_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_beat_o)),
    "stalled output beat did not hold")

  `RBFP_ASSERT_ALWAYS(a_reset_quiet, clk_i,
    (!rst_ni || unused_in || !unused_in) |-> (rst_ni || !out_valid_o),
    "output valid during reset")

endmodule

bind ring_buffer_frame_packer_unit rbfp_checker #(
  .FRAME_PAYLOAD (FRAME_PAYLOAD)
) u_rbfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_o  (out_beat_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i)
);

`default_nettype wire
